// ===== hdl/matrix_vector_transform_4x4_macros.svh =====
// Assertion macros for the 4x4 matrix-vector transform block.
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_MACROS_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define MVT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define MVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define MVT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MVT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/mvt_pkg.sv =====
// Types, constants and codes shared by the matrix-vector transform block.
`default_nettype none
package mvt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int LANES     = 4;
  localparam int ROW_W     = 2;
  localparam int MODE_W    = 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [LANES-1:0]        vec_t;
  typedef vec_t  [LANES-1:0]        mat_t;

  localparam word_t FX_ONE  = DATA_W'(64'(1) << FRAC_BITS);
  localparam word_t FX_ZERO = '0;
  localparam word_t FX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t FX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_COL  = 2'd1,
    MODE_ROW  = 2'd2
  } mode_t;

  // Per-stage load strobes and operand orientation.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic row_mode;
  } mvt_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/mvt_in_if.sv =====
// Input channel: load or transform items.
`default_nettype none
interface mvt_in_if;
  import mvt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [ROW_W-1:0]      row_index;
  word_t                 elem_0;
  word_t                 elem_1;
  word_t                 elem_2;
  word_t                 elem_3;

  modport source (output valid, mode, row_index, elem_0, elem_1, elem_2, elem_3,
                  input ready);
  modport sink   (input valid, mode, row_index, elem_0, elem_1, elem_2, elem_3,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/mvt_out_if.sv =====
// Output channel: transformed vectors.
`default_nettype none
interface mvt_out_if;
  import mvt_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_0;
  word_t out_1;
  word_t out_2;
  word_t out_3;
  logic  saturated;

  modport source (output valid, out_0, out_1, out_2, out_3, saturated, input ready);
  modport sink   (input valid, out_0, out_1, out_2, out_3, saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/mvt_matrix.sv =====
// Matrix store: 4x4 register file, row writes, operand fan-out for each lane.
`default_nettype none
module mvt_matrix (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [mvt_pkg::ROW_W-1:0] wr_row,
  input  mvt_pkg::vec_t          wr_data,
  input  mvt_pkg::mvt_ctl_t      ctl,
  output mvt_pkg::mat_t          ops
);
  import mvt_pkg::*;

  mat_t mat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < LANES; c++) begin
          mat[r][c] <= (r == c) ? FX_ONE : FX_ZERO;
        end
      end
    end else if (wr_en) begin
      mat[wr_row] <= wr_data;
    end
  end

  // Lane l gets row l for the column product, column l for the row product.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int k = 0; k < LANES; k++) begin
        ops[l][k] = ctl.row_mode ? mat[k][l] : mat[l][k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mvt_lane.sv =====
// One dot-product lane: operand regs, four multipliers, adder tree, shift/saturate.
`default_nettype none
module mvt_lane (
  input  logic              clk,
  input  mvt_pkg::mvt_ctl_t ctl,
  input  mvt_pkg::vec_t     a,
  input  mvt_pkg::vec_t     v,
  output mvt_pkg::word_t    result,
  output logic              sat
);
  import mvt_pkg::*;

  localparam int TOP_LSB = DATA_W - 1 + FRAC_BITS;

  vec_t                    a_q;
  vec_t                    v_q;
  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1-TOP_LSB:0] top;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      a_q <= a;
      v_q <= v;
    end
    if (ctl.ld2) begin
      for (int k = 0; k < LANES; k++) begin
        prod[k] <= $signed(a_q[k]) * $signed(v_q[k]);
      end
    end
    if (ctl.ld3) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (ctl.ld4) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
  end

  // Shifted value fits when every bit above its sign bit matches.
  assign top    = sum[SUM_W-1:TOP_LSB];
  assign sat    = !((&top) || !(|top));
  assign result = sat ? (sum[SUM_W-1] ? FX_MIN : FX_MAX) : sum[TOP_LSB:FRAC_BITS];

endmodule
`default_nettype wire

// ===== hdl/mvt_merge.sv =====
// Merge stage: collects lane results and the saturation flag into the output register.
`default_nettype none
module mvt_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  mvt_pkg::mvt_ctl_t          ctl,
  input  mvt_pkg::vec_t              lane_out,
  input  logic [mvt_pkg::LANES-1:0]  lane_sat,
  mvt_out_if.source                  res
);
  import mvt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctl.ld5) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      res.out_0     <= lane_out[0];
      res.out_1     <= lane_out[1];
      res.out_2     <= lane_out[2];
      res.out_3     <= lane_out[3];
      res.saturated <= |lane_sat;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/matrix_vector_transform_4x4.sv =====
// Top level: 4x4 fixed-point matrix-vector transform, four lanes and a merge stage.
//
//  channel | dir | payload                                   | transfer
//  --------+-----+-------------------------------------------+-------------------
//  cmd     | in  | mode, row_index, elem_0..elem_3           | valid & ready
//  res     | out | out_0..out_3, saturated                   | valid & ready
//
// One item per cycle sustained while res does not stall. A transform result passes
// through the operand regs, which load at the transfer edge, then multipliers, two
// adder levels and the merge register. Load items update the matrix at their transfer
// and give no result; the next item already sees the new row. Reset sets the
// matrix to identity. Each stage holds when the one after it is full and stalled,
// so bubbles collapse and cmd stays ready while a finished result waits on res,
// until the four lane stages behind it are full.
`default_nettype none
`include "matrix_vector_transform_4x4_macros.svh"
module matrix_vector_transform_4x4 (
  input  logic      clk,
  input  logic      rst,
  mvt_in_if.sink    cmd,
  mvt_out_if.source res
);
  import mvt_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic xform;
  logic load_row;
  mvt_ctl_t ctl;
  vec_t cvec;
  mat_t ops;
  vec_t lane_out;
  logic [LANES-1:0] lane_sat;

  assign rdy5 = !res.valid || res.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign cmd.ready = rdy1;

  assign xform    = cmd.valid && (cmd.mode == MODE_COL || cmd.mode == MODE_ROW);
  assign load_row = cmd.valid && cmd.ready && (cmd.mode == MODE_LOAD);

  assign ctl.ld1      = rdy1 && xform;
  assign ctl.ld2      = rdy2 && v1;
  assign ctl.ld3      = rdy3 && v2;
  assign ctl.ld4      = rdy4 && v3;
  assign ctl.ld5      = rdy5 && v4;
  assign ctl.row_mode = (cmd.mode == MODE_ROW);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= xform;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  assign cvec[0] = cmd.elem_0;
  assign cvec[1] = cmd.elem_1;
  assign cvec[2] = cmd.elem_2;
  assign cvec[3] = cmd.elem_3;

  mvt_matrix u_matrix (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_row),
    .wr_row  (cmd.row_index),
    .wr_data (cvec),
    .ctl     (ctl),
    .ops     (ops)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mvt_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .a      (ops[l]),
      .v      (cvec),
      .result (lane_out[l]),
      .sat    (lane_sat[l])
    );
  end

  mvt_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .lane_out (lane_out),
    .lane_sat (lane_sat),
    .res      (res)
  );

  // A load never enters the lanes.
  `MVT_ASSERT_NEXT(a_load_no_result, clk, rst, load_row && !v1 && !rdy2, !v1)
  // Input stalls only when every stage and the output register are full.
  `MVT_ASSERT_NOW(a_stall_full, clk, rst, !cmd.ready, v1 && v2 && v3 && v4 && res.valid)
  // A flagged result has at least one element at a rail.
  `MVT_ASSERT_NOW(a_sat_rail, clk, rst, res.valid && res.saturated,
    res.out_0 == FX_MAX || res.out_0 == FX_MIN || res.out_1 == FX_MAX ||
    res.out_1 == FX_MIN || res.out_2 == FX_MAX || res.out_2 == FX_MIN ||
    res.out_3 == FX_MAX || res.out_3 == FX_MIN)
  // An accepted transform occupies the first stage next cycle.
  `MVT_ASSERT_NEXT(a_xform_enters, clk, rst, cmd.ready && xform, v1)

endmodule
`default_nettype wire

// ===== bench/matrix_vector_transform_4x4_tb.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform.
`timescale 1ns / 1ps
`default_nettype none
module matrix_vector_transform_4x4_tb;
  import mvt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                N_RANDOM    = 600;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ROW_W-1:0]  row;
    vec_t              elems;
  } cmd_t;

  typedef struct packed {
    vec_t lanes;
    logic sat;
  } xform_t;

  logic clk = 1'b0;
  logic rst;

  mvt_in_if  cmd_if ();
  mvt_out_if res_if ();

  matrix_vector_transform_4x4 u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_t   pending_cmds[$];
  xform_t expected_results[$];
  mat_t   coeffs;
  int     mismatches = 0;
  logic   cmd_took   = 1'b0;
  logic   res_took   = 1'b0;
  int     gap_left   = 0;
  int     stall_left = 0;
  int     src_calm   = 0;
  int     snk_calm   = 0;

  // Exact 4-term dot product, floor shift, clamp to 32 bits.
  function automatic word_t fixed_dot(input vec_t a, input vec_t b, inout logic sat);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] pa;
    logic signed [SUM_W-1:0] pb;
    logic signed [SUM_W-1:0] lim_hi;
    logic signed [SUM_W-1:0] lim_lo;
    word_t                   wa;
    word_t                   wb;
    acc    = '0;
    lim_hi = FX_MAX;
    lim_lo = FX_MIN;
    for (int k = 0; k < LANES; k++) begin
      wa  = a[k];
      wb  = b[k];
      pa  = wa;
      pb  = wb;
      acc = acc + pa * pb;
    end
    acc = acc >>> FRAC_BITS;
    if (acc > lim_hi) begin
      sat = 1'b1;
      return FX_MAX;
    end
    if (acc < lim_lo) begin
      sat = 1'b1;
      return FX_MIN;
    end
    return word_t'(acc);
  endfunction

  function automatic xform_t transform_vec(input mat_t m, input logic by_row, input vec_t v);
    xform_t r;
    vec_t   line;
    r.sat = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++)
        line[j] = by_row ? m[j][i] : m[i][j];
      r.lanes[i] = fixed_dot(line, v, r.sat);
    end
    return r;
  endfunction

  // Idle draw: mostly 0..9, with occasional runs of back-to-back cycles.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic word_t pick_elem();
    case ($urandom_range(0, 9))
      0: return FX_MAX;
      1: return FX_MIN;
      2: return FX_ZERO;
      3, 4, 5: return word_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [ROW_W-1:0] row,
                         input word_t e0, input word_t e1, input word_t e2, input word_t e3);
    cmd_t c;
    c.mode  = mode;
    c.row   = row;
    c.elems = {e3, e2, e1, e0};
    pending_cmds.push_back(c);
  endtask

  // Command driver
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_took) begin
      if (cmd_took)
        gap_left = draw_wait(src_calm);
      if (gap_left > 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd_if.mode      <= c.mode;
        cmd_if.row_index <= c.row;
        cmd_if.elem_0    <= c.elems[0];
        cmd_if.elem_1    <= c.elems[1];
        cmd_if.elem_2    <= c.elems[2];
        cmd_if.elem_3    <= c.elems[3];
        cmd_if.valid     <= 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Result sink backpressure
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_took)
        stall_left = draw_wait(snk_calm);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: update the matrix copy on each command transfer, check each result transfer.
  always @(posedge clk) begin
    xform_t want;
    xform_t got;
    vec_t   v;
    cmd_took <= !rst && cmd_if.valid && cmd_if.ready;
    res_took <= !rst && res_if.valid && res_if.ready;
    if (rst) begin
      for (int r = 0; r < LANES; r++)
        for (int c = 0; c < LANES; c++)
          coeffs[r][c] = (r == c) ? FX_ONE : FX_ZERO;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        v = {cmd_if.elem_3, cmd_if.elem_2, cmd_if.elem_1, cmd_if.elem_0};
        case (cmd_if.mode)
          MODE_LOAD: coeffs[cmd_if.row_index] = v;
          MODE_COL:  expected_results.push_back(transform_vec(coeffs, 1'b0, v));
          MODE_ROW:  expected_results.push_back(transform_vec(coeffs, 1'b1, v));
          default: ;  // unused mode is dropped by the block
        endcase
      end
      if (res_if.valid && res_if.ready) begin
        got.lanes = {res_if.out_3, res_if.out_2, res_if.out_1, res_if.out_0};
        got.sat   = res_if.saturated;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual lanes=%h sat=%b", $time, got.lanes,
                   got.sat);
        end else begin
          want = expected_results.pop_front();
          for (int k = 0; k < LANES; k++)
            if (got.lanes[k] !== want.lanes[k]) begin
              mismatches++;
              $display("%0t: out_%0d expected %h actual %h", $time, k, want.lanes[k],
                       got.lanes[k]);
            end
          if (got.sat !== want.sat) begin
            mismatches++;
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          end
        end
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] m;
    int                pick;
    rst = 1'b1;

    // identity matrix, extreme vector
    add_cmd(MODE_COL, 2'd0, FX_ONE, -FX_ONE, FX_MAX, FX_MIN);
    add_cmd(MODE_ROW, 2'd1, FX_ONE, -FX_ONE, FX_MAX, FX_MIN);
    add_cmd(MODE_UNUSED, 2'd2, FX_MAX, FX_MIN, 32'sd1, -32'sd1);
    // extreme rows: sums overflow both ways, some past 64 bits
    add_cmd(MODE_LOAD, 2'd0, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    add_cmd(MODE_LOAD, 2'd1, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    add_cmd(MODE_LOAD, 2'd2, FX_MAX, FX_MIN, FX_ONE, -FX_ONE);
    add_cmd(MODE_LOAD, 2'd3, 32'sd1, FX_ZERO, FX_ZERO, FX_ZERO);
    add_cmd(MODE_COL, 2'd3, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    add_cmd(MODE_COL, 2'd0, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    add_cmd(MODE_ROW, 2'd1, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    add_cmd(MODE_ROW, 2'd2, FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    // tiny negative sum floors to -1
    add_cmd(MODE_COL, 2'd0, -32'sd1, FX_ZERO, FX_ZERO, FX_ZERO);
    add_cmd(MODE_ROW, 2'd0, FX_ZERO, FX_ZERO, FX_ZERO, -32'sd1);
    add_cmd(MODE_COL, 2'd3, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO);
    add_cmd(MODE_LOAD, 2'd0, FX_ONE, FX_ZERO, FX_ZERO, FX_ZERO);
    add_cmd(MODE_LOAD, 2'd1, FX_ZERO, FX_ONE, FX_ZERO, FX_ZERO);
    add_cmd(MODE_LOAD, 2'd2, FX_ZERO, FX_ZERO, FX_ONE, FX_ZERO);
    add_cmd(MODE_LOAD, 2'd3, FX_ZERO, FX_ZERO, FX_ZERO, FX_ONE);
    add_cmd(MODE_COL, 2'd1, 32'sh0001_8000, 32'shFFFE_8000, FX_MAX, FX_MIN);
    add_cmd(MODE_ROW, 2'd2, 32'sh0001_8000, 32'shFFFE_8000, FX_MAX, FX_MIN);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      m = MODE_LOAD;
      else if (pick < 58) m = MODE_COL;
      else if (pick < 96) m = MODE_ROW;
      else                m = MODE_UNUSED;
      add_cmd(m, ROW_W'($urandom_range(0, 3)), pick_elem(), pick_elem(), pick_elem(),
              pick_elem());
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("matrix_vector_transform_4x4_tb OK");
    else
      $display("matrix_vector_transform_4x4_tb NOT OK");
    $finish;
  end

  initial begin
    #2ms;
    $display("matrix_vector_transform_4x4_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/mvt_pkg.sv
hdl/mvt_in_if.sv
hdl/mvt_out_if.sv
hdl/mvt_matrix.sv
hdl/mvt_lane.sv
hdl/mvt_merge.sv
hdl/matrix_vector_transform_4x4.sv
bench/matrix_vector_transform_4x4_tb.sv
